@@ hw/rtl/tsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types, constants and index helpers for the timestamped sample
// interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

	localparam int DEPTH     = 8;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NCOMP     = 3;
	localparam int COMP_W    = $clog2(NCOMP);
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [COMP_W-1:0] COMP_X = COMP_W'(0);
	localparam logic [COMP_W-1:0] COMP_Y = COMP_W'(1);
	localparam logic [COMP_W-1:0] COMP_Z = COMP_W'(2);

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] sample_time;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} in_item_t;

	typedef struct packed {
		logic               status;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] stamp;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} slot_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
		return (a == IDX_W'(DEPTH - 1)) ? '0 : a + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
		return (a == '0) ? IDX_W'(DEPTH - 1) : a - IDX_W'(1);
	endfunction

endpackage

@@ hw/rtl/tsi_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [ADDR_W-1:0]        raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/tsi_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_ring
// Sample ring storage: one RAM word per slot plus per-slot valid bits, so
// that slots never written since reset read back as zero.
// ----------------------------------------------------------------------------
module tsi_ring (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [tsi_pkg::IDX_W-1:0]  waddr,
	input  tsi_pkg::slot_t             wdata,
	input  logic [tsi_pkg::IDX_W-1:0]  raddr,
	output tsi_pkg::slot_t             rdata
);

	logic [tsi_pkg::DEPTH-1:0] valid_q;
	logic                      rd_valid_q;
	logic [$bits(tsi_pkg::slot_t)-1:0] ram_rdata;

	tsi_ram #(
		.WIDTH ($bits(tsi_pkg::slot_t)),
		.DEPTH (tsi_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? tsi_pkg::slot_t'(ram_rdata) : '0;

endmodule

@@ hw/rtl/tsi_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_lerp
// Shared interpolation unit: v0 + (t - t0) * (v1 - v0) / (t1 - t0),
// truncated toward zero, with a combinational multiply and a bit-serial divide.
// ----------------------------------------------------------------------------
module tsi_lerp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] t,
	input  logic signed [31:0] t0,
	input  logic signed [31:0] t1,
	input  logic signed [31:0] v0,
	input  logic signed [31:0] v1,
	output logic               done,
	output logic signed [31:0] value
);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_ABS  = 3'd1;
	localparam logic [2:0] L_MUL  = 3'd2;
	localparam logic [2:0] L_DIV  = 3'd3;
	localparam logic [2:0] L_FIN  = 3'd4;

	logic [2:0]                  state_q;
	logic [31:0]                 dtime_q;
	logic [31:0]                 dt_q;
	logic [32:0]                 dv_q;
	logic [31:0]                 v0_q;
	logic [31:0]                 mag_q;
	logic                        neg_q;
	logic [31:0]                 rem_q;
	logic [31:0]                 lo_q;
	logic [tsi_pkg::STEP_W-1:0]  step_q;
	logic signed [31:0]          value_q;
	logic                        done_q;

	logic [32:0] dtime_w;
	logic [32:0] dt_w;
	logic [32:0] dv_w;
	logic [32:0] mag_w;
	logic [63:0] prod;
	logic [32:0] trial;
	logic [32:0] trial_sub;
	logic        ge;
	logic [32:0] sum_w;

	assign dtime_w   = {t[31], t} - {t0[31], t0};
	assign dt_w      = {t1[31], t1} - {t0[31], t0};
	assign dv_w      = {v1[31], v1} - {v0[31], v0};
	assign mag_w     = dv_q[32] ? (33'd0 - dv_q) : dv_q;
	assign prod      = dtime_q * mag_q;
	assign trial     = {rem_q, lo_q[31]};
	assign trial_sub = trial - {1'b0, dt_q};
	assign ge        = (trial >= {1'b0, dt_q});
	assign sum_w     = neg_q ? ({v0_q[31], v0_q} - {1'b0, lo_q})
	                         : ({v0_q[31], v0_q} + {1'b0, lo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_ABS;
					end
				end
				L_ABS: begin
					state_q <= L_MUL;
				end
				L_MUL: begin
					step_q  <= '0;
					// zero-length interval returns the older sample
					state_q <= (dt_q == '0) ? L_FIN : L_DIV;
				end
				L_DIV: begin
					step_q <= step_q + tsi_pkg::STEP_W'(1);
					if (step_q == tsi_pkg::STEP_W'(tsi_pkg::DIV_STEPS - 1)) begin
						state_q <= L_FIN;
					end
				end
				L_FIN: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				if (start) begin
					dtime_q <= dtime_w[31:0];
					dt_q    <= dt_w[31:0];
					dv_q    <= dv_w;
					v0_q    <= v0;
				end
			end
			L_ABS: begin
				neg_q <= dv_q[32];
				mag_q <= mag_w[31:0];
			end
			L_MUL: begin
				// product high half is always below dt, so the quotient fits 32 bits
				if (dt_q == '0) begin
					lo_q <= '0;
				end else begin
					rem_q <= prod[63:32];
					lo_q  <= prod[31:0];
				end
			end
			L_DIV: begin
				rem_q <= ge ? trial_sub[31:0] : trial[31:0];
				lo_q  <= {lo_q[30:0], ge};
			end
			L_FIN: begin
				value_q <= sum_w[31:0];
			end
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

@@ hw/rtl/timestamped_sample_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_sample_interpolator
// History ring of timestamped x/y/z samples with linear interpolation query.
// ----------------------------------------------------------------------------
// A push (opcode 0) never raises busy and gives no result. A query
// (opcode 1) holds busy through a bounds check (newest and oldest slot
// reads), then a ring scan of at most DEPTH slot pairs (one slot pair per
// cycle through the ring RAM read port), then, per component, the shared
// interpolation unit (start, sign and magnitude, multiply, a
// one-bit-per-cycle 32-step divide that a zero-length interval skips, final
// add, done). A query outside the stored time span ends after the check;
// one that finds no bracketing pair ends after the full scan.
// Each query result appears for exactly one cycle with done high, the cycle
// in which busy drops, and cannot be held off, so the receiver must take it
// on that cycle. Slots not written since reset read as time zero and value
// zero.
// ----------------------------------------------------------------------------
module timestamped_sample_interpolator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tsi_pkg::in_item_t   cmd,
	output logic                done,
	output tsi_pkg::out_item_t  result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_NEW  = 3'd1;
	localparam logic [2:0] S_OLD  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_LERP = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;

	logic [2:0]                  state_q;
	logic [tsi_pkg::IDX_W-1:0]   newest_q;
	logic [tsi_pkg::IDX_W-1:0]   scan_q;
	logic [tsi_pkg::IDX_W-1:0]   pair_q;
	logic [tsi_pkg::COMP_W-1:0]  comp_q;
	logic signed [31:0]          qtime_q;
	tsi_pkg::slot_t              newer_q;
	tsi_pkg::slot_t              older_q;
	tsi_pkg::out_item_t          result_q;
	logic                        done_q;

	logic                        accept;
	logic                        push;
	logic [tsi_pkg::IDX_W-1:0]   rd_addr;
	tsi_pkg::slot_t              rdata;
	tsi_pkg::slot_t              wdata;
	logic                        in_span;
	logic signed [31:0]          v0_sel;
	logic signed [31:0]          v1_sel;
	logic                        lerp_done;
	logic signed [31:0]          lerp_value;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign push    = accept && (cmd.opcode == tsi_pkg::OP_PUSH);
	assign rd_addr = (state_q == S_IDLE) ? newest_q : scan_q;

	assign wdata.stamp = cmd.sample_time;
	assign wdata.x     = cmd.in_x;
	assign wdata.y     = cmd.in_y;
	assign wdata.z     = cmd.in_z;

	tsi_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (push),
		.waddr  (tsi_pkg::idx_dec(newest_q)),
		.wdata  (wdata),
		.raddr  (rd_addr),
		.rdata  (rdata)
	);

	// read beat holds the older slot of the pair; newer_q holds the newer one
	assign in_span = ($signed(rdata.stamp) <= qtime_q) && (qtime_q <= $signed(newer_q.stamp));

	always_comb begin
		unique case (comp_q)
			tsi_pkg::COMP_X: begin
				v0_sel = older_q.x;
				v1_sel = newer_q.x;
			end
			tsi_pkg::COMP_Y: begin
				v0_sel = older_q.y;
				v1_sel = newer_q.y;
			end
			default: begin
				v0_sel = older_q.z;
				v1_sel = newer_q.z;
			end
		endcase
	end

	tsi_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LERP),
		.t      (qtime_q),
		.t0     (older_q.stamp),
		.t1     (newer_q.stamp),
		.v0     (v0_sel),
		.v1     (v1_sel),
		.done   (lerp_done),
		.value  (lerp_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			newest_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (push) begin
						newest_q <= tsi_pkg::idx_dec(newest_q);
					end else if (accept) begin
						state_q <= S_NEW;
					end
				end
				S_NEW: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					if (in_span) begin
						state_q <= S_SCAN;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (in_span) begin
						state_q <= S_LERP;
					end else if (pair_q == tsi_pkg::IDX_W'(tsi_pkg::DEPTH - 1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LERP: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (lerp_done) begin
						if (comp_q == tsi_pkg::COMP_Z) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_LERP;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					qtime_q <= cmd.sample_time;
					// oldest slot sits just behind the newest
					scan_q  <= tsi_pkg::idx_dec(newest_q);
				end
			end
			S_NEW: begin
				newer_q <= rdata;
				scan_q  <= tsi_pkg::idx_inc(newest_q);
			end
			S_OLD: begin
				pair_q <= '0;
				scan_q <= tsi_pkg::idx_inc(scan_q);
				if (!in_span) begin
					result_q <= '{status: tsi_pkg::ST_FAIL, out_x: '0, out_y: '0, out_z: '0};
				end
			end
			S_SCAN: begin
				if (in_span) begin
					older_q <= rdata;
					comp_q  <= tsi_pkg::COMP_X;
				end else begin
					newer_q <= rdata;
					pair_q  <= pair_q + tsi_pkg::IDX_W'(1);
					scan_q  <= tsi_pkg::idx_inc(scan_q);
					if (pair_q == tsi_pkg::IDX_W'(tsi_pkg::DEPTH - 1)) begin
						result_q <= '{status: tsi_pkg::ST_FAIL, out_x: '0, out_y: '0,
							out_z: '0};
					end
				end
			end
			S_WAIT: begin
				if (lerp_done) begin
					result_q.status <= tsi_pkg::ST_OK;
					unique case (comp_q)
						tsi_pkg::COMP_X: result_q.out_x <= lerp_value;
						tsi_pkg::COMP_Y: result_q.out_y <= lerp_value;
						default:         result_q.out_z <= lerp_value;
					endcase
					comp_q <= comp_q + tsi_pkg::COMP_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ tb/timestamped_sample_interpolator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_sample_interpolator_test
// Self-checking bench for the sample history ring and its interpolating
// query. A scoreboard class mirrors the ring, predicts every query answer
// when the beat is taken and compares each done strobe against the oldest
// prediction. Directed corners come first, then random push/query runs.
// ----------------------------------------------------------------------------
module timestamped_sample_interpolator_test;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 2 * (110 + tsi_pkg::DEPTH);
	localparam int RANDOM_BEATS = 400;

	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

	class interp_scoreboard;
		int        slot_stamp[tsi_pkg::DEPTH];
		int        slot_x[tsi_pkg::DEPTH];
		int        slot_y[tsi_pkg::DEPTH];
		int        slot_z[tsi_pkg::DEPTH];
		int        newest;
		tsi_pkg::out_item_t pending_results[$];
		int        errors;
		int        checked;
		int        out_of_span;
		int        pushes;
		int        queries;

		function logic signed [31:0] lerp_component(longint t, longint t0, longint t1,
				longint v0, longint v1);
			longint unsigned dtime;
			longint unsigned span;
			longint unsigned mag;
			longint unsigned q;
			longint          dv;
			if (t1 == t0)
				return 32'(v0);
			dtime = t - t0;
			span  = t1 - t0;
			dv    = v1 - v0;
			mag   = (dv < 0) ? -dv : dv;
			// product of two 32-bit magnitudes always fits 64 bits unsigned
			q     = dtime * mag / span;
			return (dv < 0) ? 32'(v0 - longint'(q)) : 32'(v0 + longint'(q));
		endfunction

		function tsi_pkg::out_item_t interpolate_at(longint t);
			tsi_pkg::out_item_t r;
			longint    t_new;
			longint    t_old;
			int        pn;
			int        po;
			int        k;
			r        = '0;
			r.status = tsi_pkg::ST_FAIL;
			t_old = longint'(slot_stamp[(newest + tsi_pkg::DEPTH - 1) % tsi_pkg::DEPTH]);
			t_new = longint'(slot_stamp[newest]);
			if (t < t_old || t > t_new)
				return r;
			// newest pair first; the last pair wraps from oldest back to newest
			for (k = 0; k < tsi_pkg::DEPTH; k++) begin
				pn    = (newest + k) % tsi_pkg::DEPTH;
				po    = (newest + k + 1) % tsi_pkg::DEPTH;
				t_old = longint'(slot_stamp[po]);
				if (t_old <= t && t <= t_new) begin
					r.status = tsi_pkg::ST_OK;
					r.out_x  = lerp_component(t, t_old, t_new, longint'(slot_x[po]),
						longint'(slot_x[pn]));
					r.out_y  = lerp_component(t, t_old, t_new, longint'(slot_y[po]),
						longint'(slot_y[pn]));
					r.out_z  = lerp_component(t, t_old, t_new, longint'(slot_z[po]),
						longint'(slot_z[pn]));
					return r;
				end
				t_new = t_old;
			end
			return r;
		endfunction

		function void note_beat(tsi_pkg::in_item_t b);
			if (b.opcode == tsi_pkg::OP_PUSH) begin
				newest             = (newest + tsi_pkg::DEPTH - 1) % tsi_pkg::DEPTH;
				slot_stamp[newest] = b.sample_time;
				slot_x[newest]     = b.in_x;
				slot_y[newest]     = b.in_y;
				slot_z[newest]     = b.in_z;
				pushes++;
			end else begin
				pending_results.push_back(interpolate_at(longint'(b.sample_time)));
				queries++;
			end
		endfunction

		function void check_result(tsi_pkg::out_item_t got);
			tsi_pkg::out_item_t want;
			checked++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t unexpected result: status %0d x %h y %h z %h", $realtime,
						got.status, got.out_x, got.out_y, got.out_z);
				return;
			end
			want = pending_results.pop_front();
			if (want.status == tsi_pkg::ST_FAIL)
				out_of_span++;
			if (got.status !== want.status || got.out_x !== want.out_x ||
					got.out_y !== want.out_y || got.out_z !== want.out_z) begin
				errors++;
				if (errors <= 10)
					$display({"%0t mismatch: exp status %0d x %h y %h z %h, ",
						"got status %0d x %h y %h z %h"},
						$realtime, want.status, want.out_x, want.out_y, want.out_z,
						got.status, got.out_x, got.out_y, got.out_z);
			end
		endfunction
	endclass

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic               busy;
	tsi_pkg::in_item_t  cmd    = '0;
	logic               done;
	tsi_pkg::out_item_t result;

	interp_scoreboard sb = new;
	int               cycles = 0;
	int               sent   = 0;
	bit               no_gaps = 1'b0;

	timestamped_sample_interpolator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	function automatic tsi_pkg::in_item_t push_beat(int t, int x, int y, int z);
		tsi_pkg::in_item_t b;
		b.opcode      = tsi_pkg::OP_PUSH;
		b.sample_time = t;
		b.in_x        = x;
		b.in_y        = y;
		b.in_z        = z;
		return b;
	endfunction

	// component fields of a query are don't-care, so fill them with noise
	function automatic tsi_pkg::in_item_t query_beat(int t);
		tsi_pkg::in_item_t b;
		b.opcode      = tsi_pkg::OP_QUERY;
		b.sample_time = t;
		b.in_x        = $urandom;
		b.in_y        = $urandom;
		b.in_z        = $urandom;
		return b;
	endfunction

	task automatic send_beat(input tsi_pkg::in_item_t beat);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= beat;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_beat(beat);
		sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int     n;
		int     j;
		int     slot;
		bit     paused;
		longint t_next;
		longint lo;
		longint hi;
		longint t_q;
		longint unsigned step;

		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ring is all zero after reset: only time zero is bracketed
		send_beat(query_beat(0));
		send_beat(query_beat(1));
		send_beat(query_beat(-1));

		// full time range, extreme component swings, equal stamps at the newest end
		send_beat(push_beat(S_MIN, S_MIN, S_MAX, $urandom));
		send_beat(push_beat(-70000, S_MAX, S_MIN, $urandom));
		send_beat(push_beat(0, 32'h0001_0000, -32'sh0001_0000, 0));
		send_beat(push_beat(65536, -5, 5, S_MAX));
		send_beat(push_beat(1000000, 7, 7, S_MIN));
		send_beat(push_beat(1000001, S_MIN, S_MAX, 1));
		send_beat(push_beat(S_MAX, 3, -3, 0));
		send_beat(push_beat(S_MAX, 100, 200, 300));
		send_beat(query_beat(S_MIN));
		send_beat(query_beat(S_MIN + 1));
		send_beat(query_beat(-1000000000));
		send_beat(query_beat(65536));
		send_beat(query_beat(1000000));
		send_beat(query_beat(S_MAX));
		send_beat(query_beat(S_MAX - 1));

		// newest stamp now below its neighbor: unsorted history
		send_beat(push_beat(0, 1, 2, 3));
		send_beat(query_beat(-5));
		send_beat(query_beat(500));

		while (sent < RANDOM_BEATS + 21) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				// ordered pushes from the newest stamp, then queries around the span
				n      = $urandom_range(1, 10);
				t_next = longint'(sb.slot_stamp[sb.newest]);
				for (j = 0; j < n; j++) begin
					case ($urandom_range(0, 3))
						0: step = 0;
						1, 2: step = $urandom_range(1, 5000);
						default: step = $urandom;
					endcase
					t_next += step;
					if (t_next > S_MAX)
						t_next = -longint'($urandom_range(0, 100000));
					send_beat(push_beat(int'(t_next), $urandom, $urandom, $urandom));
				end
				n = $urandom_range(1, 4);
				for (j = 0; j < n; j++) begin
					lo = longint'(sb.slot_stamp[(sb.newest + tsi_pkg::DEPTH - 1) %
						tsi_pkg::DEPTH]);
					hi = longint'(sb.slot_stamp[sb.newest]);
					case ($urandom_range(0, 5))
						0: t_q = lo;
						1: t_q = hi;
						2: begin
							slot = $urandom_range(0, tsi_pkg::DEPTH - 1);
							t_q  = longint'(sb.slot_stamp[slot]);
						end
						3: t_q = $urandom_range(0, 1) ? hi + 1 : lo - 1;
						default: begin
							if (hi >= lo)
								t_q = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
							else
								t_q = longint'(int'($urandom));
						end
					endcase
					send_beat(query_beat(int'(t_q)));
				end
			end else begin
				n = $urandom_range(1, 6);
				for (j = 0; j < n; j++) begin
					if ($urandom_range(0, 1))
						send_beat(push_beat($urandom, $urandom, $urandom, $urandom));
					else
						send_beat(query_beat($urandom));
				end
			end
			if ($urandom_range(0, 9) == 0 || (!paused && sent >= 200)) begin
				paused = 1'b1;
				drain_results();
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d pushes and %0d queries; %0d results checked, %0d out of span",
			sb.pushes, sb.queries, sb.checked, sb.out_of_span);
		$display("%0d result mismatches", sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/tsi_pkg.sv
hw/rtl/tsi_ram.sv
hw/rtl/tsi_ring.sv
hw/rtl/tsi_lerp.sv
hw/rtl/timestamped_sample_interpolator.sv
tb/timestamped_sample_interpolator_test.sv
